@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk with rst_n low
// disabling the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RCX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rcx_pkg.sv @@
// ----------------------------------------------------------------------------
// rcx_pkg
// Shared constants for the ray versus x-axis cylinder intersection block.
// ----------------------------------------------------------------------------
package rcx_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Chunk width of the pipelined multipliers: one chunk per stage.
  localparam int MUL_CW = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  localparam int OUT_USER_W = 2;
  localparam int USER_HIT   = 0;
  localparam int USER_PAR   = 1;

endpackage

@@ sv/rcx_dly.sv @@
// ----------------------------------------------------------------------------
// rcx_dly
// Enabled delay line used to keep side data aligned with the datapath.
// ----------------------------------------------------------------------------
module rcx_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1,
  parameter bit CLR   = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (CLR && !rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

@@ sv/rcx_mul.sv @@
// ----------------------------------------------------------------------------
// rcx_mul
// Pipelined signed multiplier giving magnitude and sign. The second operand
// is consumed one chunk per stage after an input register.
// ----------------------------------------------------------------------------
module rcx_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic [AW+BW-1:0]     mag,
  output logic                 neg
);

  localparam int NCH  = (BW + CW - 1) / CW;
  localparam int BPW  = NCH * CW;
  localparam int ACCW = AW + BPW;

  logic [AW-1:0]   a_abs;
  logic [BW-1:0]   b_abs;
  logic [AW-1:0]   am_r  [NCH];
  logic [BPW-1:0]  bm_r  [NCH];
  logic            neg_r [NCH+1];
  logic [ACCW-1:0] acc_r [NCH];

  assign a_abs = a[AW-1] ? (~a + 1'b1) : a;
  assign b_abs = b[BW-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0]  <= a_abs;
      bm_r[0]  <= BPW'(b_abs);
      neg_r[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_ch
    logic [AW+CW-1:0] pp;
    logic [ACCW-1:0]  acc_nxt;

    assign pp = am_r[k] * bm_r[k][k*CW +: CW];

    if (k == 0) begin : g_first
      assign acc_nxt = ACCW'(pp);
    end else begin : g_rest
      assign acc_nxt = acc_r[k-1] + (ACCW'(pp) << (k * CW));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k]   <= acc_nxt;
        neg_r[k+1] <= neg_r[k];
      end
    end

    if (k < NCH - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          am_r[k+1] <= am_r[k];
          bm_r[k+1] <= bm_r[k];
        end
      end
    end
  end

  assign mag = acc_r[NCH-1][AW+BW-1:0];
  assign neg = neg_r[NCH];

endmodule

@@ sv/rcx_sqrt.sv @@
// ----------------------------------------------------------------------------
// rcx_sqrt
// Pipelined floor square root, one result bit per stage after an input register.
// ----------------------------------------------------------------------------
module rcx_sqrt #(
  parameter int DW = 136
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DW-1:0]     rad,
  output logic [DW/2-1:0]   root
);

  localparam int N = DW / 2;

  logic [DW-1:0] rad_r  [N];
  logic [N+1:0]  rem_r  [N];
  logic [N-1:0]  root_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic         ge;

    // Bring down the next two radicand bits and try appending a one.
    assign rem_sh = {rem_r[i][N-1:0], rad_r[i][DW-1 -: 2]};
    assign trial  = {root_r[i], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) root_r[i+1] <= {root_r[i][N-2:0], ge};
    end

    if (i < N - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? rem_sh - trial : rem_sh;
          rad_r[i+1] <= rad_r[i] << 2;
        end
      end
    end
  end

  assign root = root_r[N];

endmodule

@@ sv/rcx_div.sv @@
// ----------------------------------------------------------------------------
// rcx_div
// Pipelined restoring unsigned divider, one quotient bit per stage after an
// input register, with a sign bit carried alongside.
// ----------------------------------------------------------------------------
module rcx_div #(
  parameter int NW  = 102,
  parameter int DVW = 67
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] dvs,
  input  logic           sgn,
  output logic [NW-1:0]  quo,
  output logic           quo_neg
);

  logic [NW-1:0]  n_r   [NW];
  logic [DVW-1:0] rem_r [NW];
  logic [DVW-1:0] dv_r  [NW];
  logic [NW-1:0]  q_r   [NW+1];
  logic           s_r   [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= num;
      rem_r[0] <= '0;
      dv_r[0]  <= dvs;
      q_r[0]   <= '0;
      s_r[0]   <= sgn;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DVW:0] rem_sh;
    logic [DVW:0] diff;
    logic         ge;

    assign rem_sh = {rem_r[i], n_r[i][NW-1]};
    assign diff   = rem_sh - {1'b0, dv_r[i]};
    assign ge     = rem_sh >= {1'b0, dv_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= {q_r[i][NW-2:0], ge};
        s_r[i+1] <= s_r[i];
      end
    end

    if (i < NW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
          n_r[i+1]   <= n_r[i] << 1;
          dv_r[i+1]  <= dv_r[i];
        end
      end
    end
  end

  assign quo     = q_r[NW];
  assign quo_neg = s_r[NW];

endmodule

@@ sv/ray_cylinder_x_axis_hit_top.sv @@
// ----------------------------------------------------------------------------
// ray_cylinder_x_axis_hit_top
// Ray against an infinite cylinder whose axis runs along x, fixed point.
//
//   channel  direction  payload
//   in_      request in  tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//   out_     result out  tdata: hit_x, hit_y, hit_z; tuser: hit, parallel_flag
//   cfg_     write only  index 0 center_y, 1 center_z, 2 cyl_radius
//
// One request is taken every cycle while the output is not stalled. The
// datapath holds 2*COORD_BITS+5 square-root stages plus 3*COORD_BITS+7 divider
// stages plus the multiplier and register stages.
// rst_n is synchronous and resets valid bits and configuration only.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_cylinder_x_axis_hit_top
  import rcx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first)
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hit_x, hit_y, hit_z (lowest first)
  output logic [((3*COORD_BITS+7)/8)*8-1:0]     out_tdata,
  // hit, parallel_flag (lowest first)
  output logic [OUT_USER_W-1:0]                 out_tuser,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_wdata
);

  localparam int W      = COORD_BITS;
  localparam int OUT_DW = ((3*W+7)/8)*8;
  localparam int M1W    = W + 1;
  localparam int P1W    = 2 * M1W;
  localparam int QDW    = 2 * W + 4;
  localparam int P2W    = 2 * QDW;
  localparam int DW     = P2W + 1;
  localparam int RTW    = P2W / 2;
  localparam int NUMW   = QDW + 2;
  localparam int P3W    = NUMW + W;
  localparam int DVW    = QDW - 1;
  localparam int L1     = (M1W + MUL_CW - 1) / MUL_CW + 1;
  localparam int L2     = (QDW + MUL_CW - 1) / MUL_CW + 1;
  localparam int L3     = (W + MUL_CW - 1) / MUL_CW + 1;
  localparam int LS     = RTW + 1;
  localparam int LD     = P3W + 1;
  localparam int DLY_H    = L2 + LS;
  localparam int DLY_A    = L2 + LS + 1 + L3;
  localparam int DLY_RAY  = L1 + 1 + L2 + LS + 1;
  localparam int DLY_TAIL = L3 + LD;
  localparam int DLY_V    = DLY_RAY + DLY_TAIL;

  localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic adv;

  // Configuration
  logic [W-1:0] cy_r, cz_r;
  logic [W-2:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= (W-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_Y: cy_r  <= cfg_wdata;
        CFG_CENTER_Z: cz_r  <= cfg_wdata;
        CFG_RADIUS:   rad_r <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // Input stage
  logic                   v0_r;
  logic [2:0][W-1:0]      o_r, d_r;
  logic                   par0_r;
  logic signed [M1W-1:0]  py_r, pz_r, dy_r, dz_r, rr_r;
  logic [2:0][W-1:0]      in_o, in_d;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign in_o[k] = in_tdata[k*W +: W];
    assign in_d[k] = in_tdata[(3+k)*W +: W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r    <= in_o;
      d_r    <= in_d;
      par0_r <= (in_d[1] == '0) && (in_d[2] == '0);
      py_r   <= $signed({in_o[1][W-1], in_o[1]}) - $signed({cy_r[W-1], cy_r});
      pz_r   <= $signed({in_o[2][W-1], in_o[2]}) - $signed({cz_r[W-1], cz_r});
      dy_r   <= $signed({in_d[1][W-1], in_d[1]});
      dz_r   <= $signed({in_d[2][W-1], in_d[2]});
      rr_r   <= $signed({2'b00, rad_r});
    end
  end

  // First products: d.d, p.d, p.p and r*r
  logic [P1W-1:0] m_dyy, m_dzz, m_pdy, m_pdz, m_ppy, m_ppz, m_rr;
  logic           n_dyy, n_dzz, n_pdy, n_pdz, n_ppy, n_ppz, n_rr;

  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_dyy (
    .clk(clk), .en(adv), .a(dy_r), .b(dy_r), .mag(m_dyy), .neg(n_dyy));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_dzz (
    .clk(clk), .en(adv), .a(dz_r), .b(dz_r), .mag(m_dzz), .neg(n_dzz));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_pdy (
    .clk(clk), .en(adv), .a(py_r), .b(dy_r), .mag(m_pdy), .neg(n_pdy));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_pdz (
    .clk(clk), .en(adv), .a(pz_r), .b(dz_r), .mag(m_pdz), .neg(n_pdz));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_ppy (
    .clk(clk), .en(adv), .a(py_r), .b(py_r), .mag(m_ppy), .neg(n_ppy));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_ppz (
    .clk(clk), .en(adv), .a(pz_r), .b(pz_r), .mag(m_ppz), .neg(n_ppz));
  rcx_mul #(.AW(M1W), .BW(M1W), .CW(MUL_CW)) u_mul_rr (
    .clk(clk), .en(adv), .a(rr_r), .b(rr_r), .mag(m_rr), .neg(n_rr));

  // Quadratic coefficients. Squares never carry a sign, so their sign
  // outputs only matter for the cross terms.
  logic signed [QDW-1:0] a_r, h_r, c_r;
  logic signed [QDW-1:0] a_nxt, h_nxt, c_nxt, hy, hz;
  logic                  sq_neg;

  assign sq_neg = n_dyy | n_dzz | n_ppy | n_ppz | n_rr;
  assign hy     = n_pdy ? -$signed(QDW'(m_pdy)) : $signed(QDW'(m_pdy));
  assign hz     = n_pdz ? -$signed(QDW'(m_pdz)) : $signed(QDW'(m_pdz));
  assign a_nxt  = $signed(QDW'(m_dyy)) + $signed(QDW'(m_dzz));
  assign h_nxt  = hy + hz;
  assign c_nxt  = sq_neg ? '0 : $signed(QDW'(m_ppy)) + $signed(QDW'(m_ppz))
                               - $signed(QDW'(m_rr));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      h_r <= h_nxt;
      c_r <= c_nxt;
    end
  end

  // Quarter discriminant h*h - a*c
  logic [P2W-1:0]       m_hh, m_ac;
  logic                 n_hh, n_ac;
  logic signed [DW-1:0] disc, hh_e, ac_e;
  logic                 disc_neg;
  logic [P2W-1:0]       sq_in;

  rcx_mul #(.AW(QDW), .BW(QDW), .CW(MUL_CW)) u_mul_hh (
    .clk(clk), .en(adv), .a(h_r), .b(h_r), .mag(m_hh), .neg(n_hh));
  rcx_mul #(.AW(QDW), .BW(QDW), .CW(MUL_CW)) u_mul_ac (
    .clk(clk), .en(adv), .a(a_r), .b(c_r), .mag(m_ac), .neg(n_ac));

  assign hh_e     = n_hh ? '0 : $signed(DW'(m_hh));
  assign ac_e     = $signed(DW'(m_ac));
  assign disc     = n_ac ? hh_e + ac_e : hh_e - ac_e;
  assign disc_neg = disc[DW-1];
  assign sq_in    = disc_neg ? '0 : disc[P2W-1:0];

  logic [RTW-1:0] root;

  rcx_sqrt #(.DW(P2W)) u_sqrt (
    .clk(clk), .en(adv), .rad(sq_in), .root(root));

  // Side data held alongside the square root
  logic [QDW-1:0] h_d, a_d;
  logic           dneg_d;
  logic [6*W:0]   ray_d;

  rcx_dly #(.WIDTH(QDW), .DEPTH(DLY_H)) u_dly_h (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(h_r), .q(h_d));
  rcx_dly #(.WIDTH(QDW), .DEPTH(DLY_A)) u_dly_a (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(a_r), .q(a_d));
  rcx_dly #(.WIDTH(1), .DEPTH(LS)) u_dly_dneg (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(disc_neg), .q(dneg_d));
  rcx_dly #(.WIDTH(6*W+1), .DEPTH(DLY_RAY)) u_dly_ray (
    .clk(clk), .rst_n(rst_n), .en(adv), .d({par0_r, d_r, o_r}), .q(ray_d));

  // Root choice: the nearer root unless it lies behind the origin.
  logic signed [NUMW-1:0] nh, rt, n0, n1, num_r;
  logic                   miss_r;
  logic [2:0][W-1:0]      d_d, o_d;
  logic                   par_d;

  assign d_d   = ray_d[6*W-1:3*W];
  assign o_d   = ray_d[3*W-1:0];
  assign par_d = ray_d[6*W];
  assign nh    = -$signed({{2{h_d[QDW-1]}}, h_d});
  assign rt    = $signed(NUMW'(root));
  assign n0    = nh - rt;
  assign n1    = nh + rt;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= n0[NUMW-1] ? n1 : n0;
      miss_r <= dneg_d;
    end
  end

  logic [3*W+1:0] tail_d;

  rcx_dly #(.WIDTH(3*W+2), .DEPTH(DLY_TAIL)) u_dly_tail (
    .clk(clk), .rst_n(rst_n), .en(adv), .d({miss_r, par_d, o_d}), .q(tail_d));

  // Offset along each axis: num*d_k / a, then origin + offset, saturated.
  logic [2:0][W-1:0] o_t;
  logic [2:0][W-1:0] pt_nxt;
  logic              miss_t, par_t, hit_nxt;

  assign o_t     = tail_d[3*W-1:0];
  assign par_t   = tail_d[3*W];
  assign miss_t  = tail_d[3*W+1];
  assign hit_nxt = !par_t && !miss_t;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic [P3W-1:0]       pm, qm;
    logic                 pn, qn, big;
    logic signed [W+1:0]  oe, qe, s;
    logic [W-1:0]         cl;

    rcx_mul #(.AW(NUMW), .BW(W), .CW(MUL_CW)) u_mul_nd (
      .clk(clk), .en(adv), .a(num_r), .b($signed(d_d[k])), .mag(pm), .neg(pn));

    rcx_div #(.NW(P3W), .DVW(DVW)) u_div (
      .clk(clk), .en(adv), .num(pm), .dvs(a_d[DVW-1:0]), .sgn(pn),
      .quo(qm), .quo_neg(qn));

    assign big = |qm[P3W-1:W];
    assign oe  = $signed({{2{o_t[k][W-1]}}, o_t[k]});
    assign qe  = $signed({2'b00, qm[W-1:0]});
    assign s   = qn ? oe - qe : oe + qe;

    always_comb begin
      if (big) begin
        cl = qn ? WMIN : WMAX;
      end else if (s > SMAX) begin
        cl = WMAX;
      end else if (s < SMIN) begin
        cl = WMIN;
      end else begin
        cl = s[W-1:0];
      end
    end

    assign pt_nxt[k] = hit_nxt ? cl : '0;
  end

  // Valid bits and output register
  logic                  v_end;
  logic                  out_tvalid_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic [3*W-1:0]        out_pt_r;

  rcx_dly #(.WIDTH(1), .DEPTH(DLY_V), .CLR(1'b1)) u_dly_v (
    .clk(clk), .rst_n(rst_n), .en(adv), .d(v0_r), .q(v_end));

  assign adv = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= v_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pt_r             <= pt_nxt;
      out_user_r[USER_HIT] <= hit_nxt;
      out_user_r[USER_PAR] <= par_t;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'(out_pt_r);
  assign out_tuser  = out_user_r;

  `RCX_ASSERT_IMP(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready, "request taken while output stalled")
  `RCX_ASSERT_NXT(a_end_reaches_out, adv && v_end, out_tvalid, "finished result not presented")
  `RCX_ASSERT_IMP(a_hit_not_parallel, out_tvalid && out_tuser[USER_HIT], !out_tuser[USER_PAR], "hit flagged on a parallel ray")

endmodule

@@ test/ray_cylinder_x_axis_hit_checker.sv @@
// ----------------------------------------------------------------------------
// Hit point checker
// Watches the ray and result channels and the register port. It predicts the
// hit point of every accepted ray with exact wide integer arithmetic and
// compares each result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_cylinder_x_axis_hit_checker
  import rcx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [191:0]         in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [95:0]          out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  output int                   pending,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wint_t;

  typedef struct packed {
    logic        hit;
    logic        parallel;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] hz;
  } hit_point_t;

  hit_point_t  hit_queue[$];
  logic [31:0] axis_y, axis_z;
  logic [30:0] radius;

  function automatic wint_t floor_sqrt(wint_t n);
    wint_t res, bit_v, t;
    res = 0;
    bit_v = wint_t'(1) <<< 252;
    while (bit_v != 0) begin
      t = res + bit_v;
      if (n >= t) begin
        n = n - t;
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_coord(wint_t v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic hit_point_t trace_ray(logic [191:0] ray);
    wint_t o[3], d[3], py, pz, a, h, c, disc, root, num, q, rr;
    hit_point_t r;
    for (int k = 0; k < 3; k++) begin
      o[k] = wint_t'($signed(ray[32*k +: 32]));
      d[k] = wint_t'($signed(ray[96 + 32*k +: 32]));
    end
    r = '0;
    py = o[1] - wint_t'($signed(axis_y));
    pz = o[2] - wint_t'($signed(axis_z));
    a = d[1] * d[1] + d[2] * d[2];
    if (a == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    h = py * d[1] + pz * d[2];
    rr = wint_t'(radius);
    c = py * py + pz * pz - rr * rr;
    disc = h * h - a * c;
    if (disc < 0) return r;
    root = floor_sqrt(disc);
    num = -h - root;
    if (num < 0) num = -h + root;
    r.hit = 1'b1;
    // Signed division truncates toward zero, as the datapath does.
    q = (num * d[0]) / a;  r.hx = clamp_coord(o[0] + q);
    q = (num * d[1]) / a;  r.hy = clamp_coord(o[1] + q);
    q = (num * d[2]) / a;  r.hz = clamp_coord(o[2] + q);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = hit_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    hit_point_t e;
    if (!rst_n) begin
      axis_y <= '0;
      axis_z <= '0;
      radius <= 31'(1 << 16);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_Y: axis_y <= cfg_wdata;
          CFG_CENTER_Z: axis_z <= cfg_wdata;
          CFG_RADIUS:   radius <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) hit_queue = {hit_queue, trace_ray(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          e = hit_queue.pop_front();
          if (out_tuser[USER_HIT] !== e.hit)
            report_mismatch("hit", 32'(out_tuser[USER_HIT]), 32'(e.hit));
          if (out_tuser[USER_PAR] !== e.parallel)
            report_mismatch("parallel_flag", 32'(out_tuser[USER_PAR]), 32'(e.parallel));
          if (out_tdata[31:0] !== e.hx) report_mismatch("hit_x", out_tdata[31:0], e.hx);
          if (out_tdata[63:32] !== e.hy) report_mismatch("hit_y", out_tdata[63:32], e.hy);
          if (out_tdata[95:64] !== e.hz) report_mismatch("hit_z", out_tdata[95:64], e.hz);
        end
      end
    end
  end
endmodule

@@ test/tb_ray_cylinder_x_axis_hit_top.sv @@
// ----------------------------------------------------------------------------
// Ray versus x-axis cylinder testbench
// Drives directed and random rays through several cylinder settings with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ray_cylinder_x_axis_hit_top;
  import rcx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [191:0] in_tdata;
  logic [95:0]  out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;
  int pending, fail_count;
  int hold_cycles;
  bit stall_on;

  ray_cylinder_x_axis_hit_top dut (.*);

  ray_cylinder_x_axis_hit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus an explicit long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (!stall_on) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        out_tready <= 1'b0;
        hold_cycles = $urandom_range(10, 60);
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cylinder(logic [31:0] cy, logic [31:0] cz, logic [31:0] r);
    wait_idle();
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, r);
    cfg_we <= 1'b0;
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    in_tvalid <= 1'b1;
    in_tdata <= {dz, dy, dx, oz, oy, ox};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (stall_on && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 99) < 5) repeat ($urandom_range(20, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Mix of full-range words, values within four units of base, values within one unit of zero, and zero.
  function automatic logic [31:0] pick_coord(logic [31:0] base);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return $urandom;
    if (sel < 3) return 32'h0;
    if (sel < 7) return base + 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
  endfunction

  task automatic random_rays(int n, logic [31:0] cy, logic [31:0] cz);
    logic [31:0] dy, dz;
    repeat (n) begin
      dy = pick_coord(32'h0);
      dz = pick_coord(32'h0);
      if ($urandom_range(0, 29) == 0) begin
        dy = 0;
        dz = 0;
      end
      send_ray(pick_coord(32'h0), pick_coord(cy), pick_coord(cz), pick_coord(32'h0), dy, dz);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_cycles = 0;
    stall_on = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays against the unit cylinder left by reset.
    send_ray(0, 0, 0, ONE, 0, 0);                          // parallel to the axis
    send_ray(0, 0, 0, 0, 0, 0);                            // zero direction
    send_ray(0, -(3 * ONE), 0, 0, ONE, 0);                 // enters from outside
    send_ray(ONE, 0, 0, ONE, ONE, 0);                      // starts inside
    send_ray(0, 3 * ONE, 0, 0, ONE, 0);                    // both roots behind
    send_ray(0, 3 * ONE, 0, 0, 0, ONE);                    // clear miss
    send_ray(0, -(2 * ONE), ONE, 0, ONE, 0);               // tangent
    send_ray(32'h7fffffff, 0, 0, 32'h7fffffff, 1, 0);      // saturates high in x
    send_ray(32'h80000000, 0, 0, 32'h80000000, 1, 0);      // saturates low in x
    send_ray(32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h80000000);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_ray(0, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_ray(0, 0, 0, 0, 0, 1);

    set_cylinder(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_ray(0, 0, 0, 0, ONE, ONE);
    send_ray(0, 32'h7fffffff, 32'h80000000, ONE, 32'h80000000, 32'h7fffffff);
    set_cylinder(0, 0, 0);
    send_ray(0, ONE, 0, 0, 32'hffff0000, 0);               // zero radius on axis
    send_ray(0, ONE, ONE, 0, 32'hffff0000, 32'hffff0000);

    // Random phases through several settings.
    stall_on = 1'b1;
    set_cylinder(0, 0, ONE);
    random_rays(350, 0, 0);
    set_cylinder(32'h0003_0000, 32'hfffe_0000, 32'h0002_8000);
    // Long hold-off while requests keep coming, to fill the pipeline.
    hold_cycles = 600;
    random_rays(350, 32'h0003_0000, 32'hfffe_0000);
    stall_on = 1'b0;
    set_cylinder(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    random_rays(250, 32'h80000000, 32'h7fffffff);
    stall_on = 1'b1;
    set_cylinder(32'h7fffffff, 32'h80000000, 0);
    random_rays(250, 32'h7fffffff, 32'h80000000);
    begin
      logic [31:0] ry, rz;
      ry = $urandom;
      rz = $urandom;
      set_cylinder(ry, rz, $urandom);
      random_rays(250, ry, rz);
      ry = $urandom_range(0, 1 << 20);
      rz = -$urandom_range(0, 1 << 20);
      set_cylinder(ry, rz, $urandom_range(1, 1 << 19));
      random_rays(250, ry, rz);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
